FILE: rtl/barometric_pressure_compensation_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric pressure compensation block
// Shared concurrent-assertion wrappers on the block clock; two are off during reset.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define BPC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bpc assertion failed");

// next-cycle implication, off during reset
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bpc assertion failed");

// next-cycle implication, always on
`define BPC_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("bpc assertion failed");

`endif

FILE: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, constants and helpers shared by the compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package bpc_pkg;

   localparam int DivW    = 32;
   localparam int DivTagW = 53;

   localparam logic [2:0] CsrCalA = 3'd0;
   localparam logic [2:0] CsrCalB = 3'd1;
   localparam logic [2:0] CsrCalC = 3'd2;
   localparam logic [2:0] CsrCalD = 3'd3;
   localparam logic [2:0] CsrOss  = 3'd4;

   localparam logic [31:0] TempOffset = 32'd4000;
   localparam logic [31:0] PScale     = 32'd50000;
   localparam logic [31:0] PolyC1     = 32'd3038;
   localparam logic [31:0] PolyC2     = 32'hFFFF_E343;   // -7357
   localparam logic [31:0] PolyC3     = 32'd3791;
   localparam logic [31:0] Recip10    = 32'hCCCC_CCCD;   // ceil(2^35 / 10)
   localparam logic [31:0] HalfScale  = 32'd32768;

   typedef struct packed {
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [15:0] ac5;
      logic [15:0] ac6;
      logic [15:0] b1;
      logic [15:0] b2;
      logic [15:0] mc;
      logic [15:0] md;
      logic [1:0]  oss;
   } cal_type;

   typedef logic [DivTagW-1:0] div_tag_type;

   function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
      return $unsigned($signed(v) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Unsigned 32-bit restoring divider, one quotient bit per pipeline stage,
// with a tag carried alongside each transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module bpc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [31:0]          in_num,
   input  logic [31:0]          in_den,
   input  bpc_pkg::div_tag_type in_tag,
   output logic                 out_valid,
   output logic [31:0]          out_quo,
   output bpc_pkg::div_tag_type out_tag
);
   import bpc_pkg::*;

   logic        vld_ff [DivW];
   logic [31:0] rem_ff [DivW];
   logic [31:0] num_ff [DivW];
   logic [31:0] den_ff [DivW];
   logic [31:0] quo_ff [DivW];
   div_tag_type tag_ff [DivW];

   for (genvar s = 0; s < DivW; s++) begin : g_stage
      logic        prev_vld;
      logic [31:0] prev_rem, prev_num, prev_den, prev_quo;
      div_tag_type prev_tag;
      logic [33:0] trial;
      logic        fit;
      logic [31:0] rem_in;

      if (s == 0) begin : g_first
         assign prev_vld = in_valid;
         assign prev_rem = '0;
         assign prev_num = in_num;
         assign prev_den = in_den;
         assign prev_quo = '0;
         assign prev_tag = in_tag;
      end else begin : g_rest
         assign prev_vld = vld_ff[s-1];
         assign prev_rem = rem_ff[s-1];
         assign prev_num = num_ff[s-1];
         assign prev_den = den_ff[s-1];
         assign prev_quo = quo_ff[s-1];
         assign prev_tag = tag_ff[s-1];
      end

      assign trial  = {1'b0, prev_rem, prev_num[31]} - {2'b00, prev_den};
      assign fit    = ~trial[33];
      assign rem_in = fit ? trial[31:0] : {prev_rem[30:0], prev_num[31]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (advance) begin
            vld_ff[s] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s] <= rem_in;
            num_ff[s] <= {prev_num[30:0], 1'b0};
            den_ff[s] <= prev_den;
            quo_ff[s] <= {prev_quo[30:0], fit};
            tag_ff[s] <= prev_tag;
         end
      end
   end

   assign out_valid = vld_ff[DivW-1];
   assign out_quo   = quo_ff[DivW-1];
   assign out_tag   = tag_ff[DivW-1];

endmodule
`default_nettype wire

FILE: rtl/bpc_comp.sv
// ----------------------------------------------------------------------------
// bpc_comp
// Temperature finish and pressure scale terms between the two dividers.
// ----------------------------------------------------------------------------
`default_nettype none
module bpc_comp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  bpc_pkg::cal_type     cal,
   input  logic                 in_valid,
   input  logic [31:0]          in_quo,
   input  bpc_pkg::div_tag_type in_tag,
   output logic                 out_valid,
   output logic [31:0]          out_num,
   output logic [31:0]          out_den,
   output bpc_pkg::div_tag_type out_tag
);
   import bpc_pkg::*;

   logic [31:0] tx1;
   logic [18:0] up_tag;
   logic        derr, qneg;
   assign tx1    = in_tag[52:21];
   assign derr   = in_tag[20];
   assign up_tag = in_tag[19:1];
   assign qneg   = in_tag[0];

   logic [7:0] vld_ff;

   // stage 1
   logic [31:0] b5_ff, b5_in;
   logic [18:0] up1_ff;
   logic        err1_ff;
   assign b5_in = tx1 + (qneg ? (32'd0 - in_quo) : in_quo);

   // stage 2
   logic [31:0] b6_ff, tval_ff;
   logic [18:0] up2_ff;
   logic        err2_ff;

   // stage 3
   logic [31:0] sqf_ff, a2_ff, a3_ff;
   logic [63:0] tprod_ff;
   logic        tneg_ff, err3_ff;
   logic [18:0] up3_ff;
   logic [31:0] tabs;
   assign tabs = tval_ff[31] ? (32'd0 - tval_ff) : tval_ff;

   // stage 4
   logic [31:0] sq_ff, x2_ff, x1b_ff;
   logic [15:0] deg4_ff, deg_in;
   logic [18:0] up4_ff;
   logic        err4_ff;
   logic [31:0] sdeg;
   assign sdeg = tneg_ff ? (32'd0 - {3'b000, tprod_ff[63:35]}) : {3'b000, tprod_ff[63:35]};
   always_comb begin
      priority if (!sdeg[31] && sdeg > 32'h0000_7FFF) begin
         deg_in = 16'h7FFF;
      end else if (sdeg[31] && sdeg < 32'hFFFF_8000) begin
         deg_in = 16'h8000;
      end else begin
         deg_in = sdeg[15:0];
      end
   end

   // stage 5
   logic [31:0] b2sq_ff, b1sq_ff, x2b5_ff, x1b5_ff;
   logic [15:0] deg5_ff;
   logic [18:0] up5_ff;
   logic        err5_ff;

   // stage 6
   logic [31:0] x3_ff, x3b_ff;
   logic [15:0] deg6_ff;
   logic [18:0] up6_ff;
   logic        err6_ff;

   // stage 7
   logic [31:0] b3_ff, b4p_ff, b3_in;
   logic [15:0] deg7_ff;
   logic [18:0] up7_ff;
   logic        err7_ff;
   assign b3_in = asr32((((sx16(cal.ac1) << 2) + x3_ff) << cal.oss) + 32'd2, 5'd2);

   // stage 8
   logic [31:0] b4_ff, b7_ff;
   logic [15:0] deg8_ff;
   logic        err8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[6:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b5_ff    <= b5_in;
         up1_ff   <= up_tag;
         err1_ff  <= derr;

         b6_ff    <= b5_ff - TempOffset;
         tval_ff  <= asr32(b5_ff + 32'd8, 5'd4);
         up2_ff   <= up1_ff;
         err2_ff  <= err1_ff;

         sqf_ff   <= b6_ff * b6_ff;
         a2_ff    <= sx16(cal.ac2) * b6_ff;
         a3_ff    <= sx16(cal.ac3) * b6_ff;
         tprod_ff <= {32'd0, tabs} * {32'd0, Recip10};
         tneg_ff  <= tval_ff[31];
         up3_ff   <= up2_ff;
         err3_ff  <= err2_ff;

         sq_ff    <= asr32(sqf_ff, 5'd12);
         x2_ff    <= asr32(a2_ff, 5'd11);
         x1b_ff   <= asr32(a3_ff, 5'd13);
         deg4_ff  <= deg_in;
         up4_ff   <= up3_ff;
         err4_ff  <= err3_ff;

         b2sq_ff  <= sx16(cal.b2) * sq_ff;
         b1sq_ff  <= sx16(cal.b1) * sq_ff;
         x2b5_ff  <= x2_ff;
         x1b5_ff  <= x1b_ff;
         deg5_ff  <= deg4_ff;
         up5_ff   <= up4_ff;
         err5_ff  <= err4_ff;

         x3_ff    <= asr32(b2sq_ff, 5'd11) + x2b5_ff;
         x3b_ff   <= asr32(asr32(b1sq_ff, 5'd16) + x1b5_ff + 32'd2, 5'd2);
         deg6_ff  <= deg5_ff;
         up6_ff   <= up5_ff;
         err6_ff  <= err5_ff;

         b3_ff    <= b3_in;
         b4p_ff   <= {16'd0, cal.ac4} * (x3b_ff + HalfScale);
         deg7_ff  <= deg6_ff;
         up7_ff   <= up6_ff;
         err7_ff  <= err6_ff;

         b4_ff    <= {15'd0, b4p_ff[31:15]};
         b7_ff    <= ({13'd0, up7_ff} - b3_ff) * (PScale >> cal.oss);
         deg8_ff  <= deg7_ff;
         err8_ff  <= err7_ff;
      end
   end

   assign out_valid = vld_ff[7];
   assign out_num   = b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
   assign out_den   = b4_ff;
   assign out_tag   = {35'd0, b7_ff[31], deg8_ff, err8_ff | (b4_ff == 32'd0)};

endmodule
`default_nettype wire

FILE: rtl/bpc_poly.sv
// ----------------------------------------------------------------------------
// bpc_poly
// Second-order pressure correction and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module bpc_poly (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [31:0]          in_quo,
   input  bpc_pkg::div_tag_type in_tag,
   output logic                 out_valid,
   output logic [31:0]          out_pressure,
   output logic [15:0]          out_deg,
   output logic                 out_err
);
   import bpc_pkg::*;

   logic [3:0]  vld_ff;
   logic [31:0] p1_ff, p2_ff, p3_ff, sqp_ff, m2_ff, x1m_ff, x2_ff;
   logic [31:0] ps8, pres_in;
   logic [15:0] deg1_ff, deg2_ff, deg3_ff, deg_ff;
   logic        err1_ff, err2_ff, err3_ff, err_ff;
   logic [31:0] pres_ff;

   assign ps8     = asr32(p1_ff, 5'd8);
   assign pres_in = p3_ff + asr32(asr32(x1m_ff, 5'd16) + x2_ff + PolyC3, 5'd4);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff   <= in_tag[17] ? {in_quo[30:0], 1'b0} : in_quo;
         deg1_ff <= in_tag[16:1];
         err1_ff <= in_tag[0];

         sqp_ff  <= ps8 * ps8;
         m2_ff   <= p1_ff * PolyC2;
         p2_ff   <= p1_ff;
         deg2_ff <= deg1_ff;
         err2_ff <= err1_ff;

         x1m_ff  <= sqp_ff * PolyC1;
         x2_ff   <= asr32(m2_ff, 5'd16);
         p3_ff   <= p2_ff;
         deg3_ff <= deg2_ff;
         err3_ff <= err2_ff;

         pres_ff <= err3_ff ? 32'd0 : pres_in;
         deg_ff  <= err3_ff ? 16'd0 : deg3_ff;
         err_ff  <= err3_ff;
      end
   end

   assign out_valid    = vld_ff[3];
   assign out_pressure = pres_ff;
   assign out_deg      = deg_ff;
   assign out_err      = err_ff;

endmodule
`default_nettype wire

FILE: rtl/barometric_pressure_compensation_top.sv
// Throughput: one transaction per cycle; two 32-stage bit-per-stage dividers
// set the depth, and the whole pipeline holds while rsp_tvalid is high and
// rsp_tready is low. Reset: synchronous; clears all valid bits, calibration
// words to zero, oversampling mode to three.
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// Pipelined integer compensation of raw temperature and pressure readings.
// ----------------------------------------------------------------------------
`default_nettype none
module barometric_pressure_compensation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temperature[15:0], raw_pressure[34:16], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pressure_pa[31:0], temperature_deg[47:32]
   output logic        rsp_tuser,   // divide_error[0]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   import bpc_pkg::*;

   logic [47:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_c_ff, cal_d_ff;
   logic [1:0]  oss_ff;
   cal_type     cal;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         cal_d_ff <= '0;
         oss_ff   <= 2'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrCalA: cal_a_ff <= csr_wdata;
            CsrCalB: cal_b_ff <= csr_wdata;
            CsrCalC: cal_c_ff <= csr_wdata[31:0];
            CsrCalD: cal_d_ff <= csr_wdata[31:0];
            CsrOss:  oss_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign cal = '{ac1: cal_a_ff[47:32], ac2: cal_a_ff[31:16], ac3: cal_a_ff[15:0],
                  ac4: cal_b_ff[47:32], ac5: cal_b_ff[31:16], ac6: cal_b_ff[15:0],
                  b1: cal_c_ff[31:16], b2: cal_c_ff[15:0],
                  mc: cal_d_ff[31:16], md: cal_d_ff[15:0], oss: oss_ff};

   logic advance;
   assign advance    = rsp_tready | ~rsp_tvalid;
   assign req_tready = advance;

   // front stages: difference, product, divider operands
   logic [3:0]  vld_ff;
   logic [15:0] ut_ff;
   logic [18:0] up1_ff, up2_ff, up3_ff, up4_ff;
   logic [16:0] d_ff;
   logic [33:0] prod_ff;
   logic [31:0] tx1_ff, den_ff, tx1b_ff, anum_ff, aden_ff;
   logic        derr_ff, qneg_ff;
   logic [31:0] tnum;

   assign tnum = {{5{cal.mc[15]}}, cal.mc, 11'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ut_ff   <= req_tdata[15:0];
         up1_ff  <= req_tdata[34:16];

         d_ff    <= {1'b0, ut_ff} - {1'b0, cal.ac6};
         up2_ff  <= up1_ff;

         prod_ff <= 34'($signed(d_ff) * $signed({1'b0, cal.ac5}));
         up3_ff  <= up2_ff;

         tx1_ff  <= {{13{prod_ff[33]}}, prod_ff[33:15]};
         den_ff  <= {{13{prod_ff[33]}}, prod_ff[33:15]} + sx16(cal.md);
         up4_ff  <= up3_ff;

         tx1b_ff <= tx1_ff;
         anum_ff <= tnum[31] ? (32'd0 - tnum) : tnum;
         aden_ff <= den_ff[31] ? (32'd0 - den_ff) : den_ff;
         qneg_ff <= tnum[31] ^ den_ff[31];
         derr_ff <= (den_ff == 32'd0);
      end
   end

   logic        vld5_ff;
   logic [18:0] up5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
      end else if (advance) begin
         vld5_ff <= vld_ff[3];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         up5_ff <= up4_ff;
      end
   end

   logic        da_valid, db_in_valid, db_valid;
   logic [31:0] da_quo, db_num, db_den, db_quo;
   div_tag_type da_tag, db_in_tag, db_tag;

   bpc_div u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (vld5_ff),
      .in_num    (anum_ff),
      .in_den    (aden_ff),
      .in_tag    ({tx1b_ff, derr_ff, up5_ff, qneg_ff}),
      .out_valid (da_valid),
      .out_quo   (da_quo),
      .out_tag   (da_tag)
   );

   bpc_comp u_comp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cal       (cal),
      .in_valid  (da_valid),
      .in_quo    (da_quo),
      .in_tag    (da_tag),
      .out_valid (db_in_valid),
      .out_num   (db_num),
      .out_den   (db_den),
      .out_tag   (db_in_tag)
   );

   bpc_div u_div_press (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (db_in_valid),
      .in_num    (db_num),
      .in_den    (db_den),
      .in_tag    (db_in_tag),
      .out_valid (db_valid),
      .out_quo   (db_quo),
      .out_tag   (db_tag)
   );

   bpc_poly u_poly (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (db_valid),
      .in_quo       (db_quo),
      .in_tag       (db_tag),
      .out_valid    (rsp_tvalid),
      .out_pressure (rsp_tdata[31:0]),
      .out_deg      (rsp_tdata[47:32]),
      .out_err      (rsp_tuser)
   );

endmodule
`default_nettype wire

FILE: rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks on the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "barometric_pressure_compensation_top_macros.svh"
module bpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);
   `BPC_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_tvalid)
   `BPC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `BPC_ASSERT_NOW(a_err_zero, rsp_tvalid && rsp_tuser, rsp_tdata == 48'd0)
   `BPC_ASSERT_NOW(a_ready_follows, 1'b1, req_tready == (rsp_tready || !rsp_tvalid))
endmodule

bind barometric_pressure_compensation_top bpc_checker u_checker (.*);
`default_nettype wire
